// ===== rtl/tpdq_pkg.sv =====
// tpdq_pkg: field widths, stream packing and request codes for the tree path distance unit
// no dependencies; imported by tpdq_table and tree_path_distance_query_unit
package tpdq_pkg;

  localparam int VtxW   = 10;
  localparam int LvlW   = 10;
  localparam int RdistW = 32;
  localparam int PathW  = 32;

  // s_axis tdata: vertex, parent_vertex, tree_level, root_distance, other_vertex
  localparam int InVtxLo    = 0;
  localparam int InParLo    = InVtxLo + VtxW;
  localparam int InLvlLo    = InParLo + VtxW;
  localparam int InRdistLo  = InLvlLo + LvlW;
  localparam int InOtherLo  = InRdistLo + RdistW;
  localparam int InRawW     = InOtherLo + VtxW;
  localparam int InDataW    = ((InRawW + 7) / 8) * 8;

  // m_axis tdata: path_distance, common_ancestor
  localparam int OutPathLo  = 0;
  localparam int OutAncLo   = OutPathLo + PathW;
  localparam int OutRawW    = OutAncLo + VtxW;
  localparam int OutDataW   = ((OutRawW + 7) / 8) * 8;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage

// ===== rtl/tree_path_distance_query_unit.sv =====
// tree_path_distance_query_unit: lowest common ancestor and path distance over a stored tree
// depends on tpdq_pkg and tpdq_table
//
//   channel  dir  fields
//   s_axis   in   tuser: func; tdata: vertex, parent_vertex, tree_level, root_distance,
//                 other_vertex
//   m_axis   out  tdata: path_distance, common_ancestor
//
// a load request writes one table entry and gives no result
// a query walks parent links over the two table read ports, first lifting the deeper vertex
// and then both together until they meet; each walk phase is capped at MAX_VERTICES steps
// s_axis_tready is high only while no query is walking; a finished result waits in the
// output register, and the walk holds its last step while that register is full
// reset clears control state only; table contents are undefined until loaded
module tree_path_distance_query_unit #(
  parameter int MAX_VERTICES = 1024,
  parameter int DEPTH_BITS   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // vertex, parent_vertex, tree_level, root_distance, other_vertex, zero fill
  input  logic [tpdq_pkg::InDataW-1:0]  s_axis_tdata_i,
  // func
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // path_distance, common_ancestor, zero fill
  output logic [tpdq_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import tpdq_pkg::*;

  localparam int IdxW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CntW = $clog2(MAX_VERTICES + 1);
  localparam logic [CntW-1:0] StepMax = CntW'(MAX_VERTICES);
  localparam logic [19:0] ModVal = 20'(MAX_VERTICES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_LIFT = 2'd2;
  localparam logic [1:0] ST_MEET = 2'd3;

  function automatic logic [VtxW-1:0] slot(input logic [VtxW-1:0] v);
    logic [19:0] r;
    r = {10'd0, v};
    if (MAX_VERTICES < 1024) begin
      for (int k = 9; k >= 0; k--) begin
        if (r >= (ModVal << k)) begin
          r = r - (ModVal << k);
        end
      end
    end
    return r[VtxW-1:0];
  endfunction

  logic [1:0]        state_q, state_d;
  logic [IdxW-1:0]   a_q, a_d, b_q, b_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DEPTH_BITS-1:0] sum_q, sum_d;
  logic              out_valid_q, out_valid_d;
  logic [PathW-1:0]  path_q, path_d;
  logic [VtxW-1:0]   anc_q, anc_d;

  logic [VtxW-1:0]   in_vertex, in_parent, in_other;
  logic [LvlW-1:0]   in_level;
  logic [RdistW-1:0] in_rdist;
  logic              accept;
  logic              out_free;
  logic              meet_done;
  logic [DEPTH_BITS-1:0] dist_diff;

  logic [IdxW-1:0]       par_a, par_b;
  logic [LvlW-1:0]       lvl_a, lvl_b;
  logic [DEPTH_BITS-1:0] dep_a, dep_b;

  assign in_vertex = s_axis_tdata_i[InVtxLo +: VtxW];
  assign in_parent = s_axis_tdata_i[InParLo +: VtxW];
  assign in_level  = s_axis_tdata_i[InLvlLo +: LvlW];
  assign in_rdist  = s_axis_tdata_i[InRdistLo +: RdistW];
  assign in_other  = s_axis_tdata_i[InOtherLo +: VtxW];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign meet_done       = (cnt_q == StepMax) || (a_q == b_q);
  assign dist_diff       = sum_q - (dep_a << 1);

  tpdq_table #(
    .Depth  (MAX_VERTICES),
    .IdxW   (IdxW),
    .DepthW (DEPTH_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .we_i       (accept && (s_axis_tuser_i == FUNC_LOAD)),
    .waddr_i    (IdxW'(slot(in_vertex))),
    .wparent_i  (IdxW'(slot(in_parent))),
    .wlevel_i   (in_level),
    .wdepth_i   (DEPTH_BITS'(in_rdist)),
    .raddr_a_i  (a_d),
    .raddr_b_i  (b_d),
    .parent_a_o (par_a),
    .level_a_o  (lvl_a),
    .depth_a_o  (dep_a),
    .parent_b_o (par_b),
    .level_b_o  (lvl_b),
    .depth_b_o  (dep_b)
  );

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    path_d      = path_q;
    anc_d       = anc_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept && (s_axis_tuser_i == FUNC_QUERY)) begin
          a_d     = IdxW'(slot(in_vertex));
          b_d     = IdxW'(slot(in_other));
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        sum_d   = dep_a + dep_b;
        cnt_d   = '0;
        state_d = ST_LIFT;
      end
      ST_LIFT: begin
        if ((cnt_q == StepMax) || (lvl_a == lvl_b)) begin
          cnt_d   = '0;
          state_d = ST_MEET;
        end else begin
          if (lvl_a > lvl_b) begin
            a_d = par_a;
          end else begin
            b_d = par_b;
          end
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_MEET: begin
        if (meet_done) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            path_d      = PathW'(dist_diff);
            anc_d       = VtxW'(a_q);
            state_d     = ST_IDLE;
          end
        end else begin
          a_d   = par_a;
          b_d   = par_b;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    sum_q  <= sum_d;
    path_q <= path_d;
    anc_q  <= anc_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - OutRawW)'(0), anc_q, path_q};

endmodule

// ===== rtl/tpdq_table.sv =====
// tpdq_table: vertex table holding parent, level and root distance per entry
// one write port, two registered read ports; uses tpdq_pkg
module tpdq_table #(
  parameter int Depth  = 1024,
  parameter int IdxW   = 10,
  parameter int DepthW = 32
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [IdxW-1:0]             waddr_i,
  input  logic [IdxW-1:0]             wparent_i,
  input  logic [tpdq_pkg::LvlW-1:0]   wlevel_i,
  input  logic [DepthW-1:0]           wdepth_i,
  input  logic [IdxW-1:0]             raddr_a_i,
  input  logic [IdxW-1:0]             raddr_b_i,
  output logic [IdxW-1:0]             parent_a_o,
  output logic [tpdq_pkg::LvlW-1:0]   level_a_o,
  output logic [DepthW-1:0]           depth_a_o,
  output logic [IdxW-1:0]             parent_b_o,
  output logic [tpdq_pkg::LvlW-1:0]   level_b_o,
  output logic [DepthW-1:0]           depth_b_o
);
  import tpdq_pkg::*;

  localparam int WordW = IdxW + LvlW + DepthW;

  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rdata_a_q;
  logic [WordW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wparent_i, wlevel_i, wdepth_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign depth_a_o  = rdata_a_q[DepthW-1:0];
  assign level_a_o  = rdata_a_q[DepthW+LvlW-1:DepthW];
  assign parent_a_o = rdata_a_q[WordW-1:DepthW+LvlW];
  assign depth_b_o  = rdata_b_q[DepthW-1:0];
  assign level_b_o  = rdata_b_q[DepthW+LvlW-1:DepthW];
  assign parent_b_o = rdata_b_q[WordW-1:DepthW+LvlW];

endmodule
